// ===== rtl/utf8tok_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8tok_pkg: shared types, constants and code point map
// Types and helpers for the byte-level token text decoder.
// ----------------------------------------------------------------------------
package utf8tok_pkg;

    localparam int MAX_RES  = 4;   // results one input byte can cause
    localparam int HELD_MAX = 3;   // bytes held for an unfinished sequence

    // UTF-8 lead and continuation byte classes
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_CODE  = 8'h80;
    localparam logic [7:0] CONT_BITS  = 8'h3F;

    // printable ranges that map to themselves
    localparam logic [7:0] PRINT_LO   = 8'h21;
    localparam logic [7:0] PRINT_HI   = 8'h7E;
    localparam logic [7:0] LATIN_LO   = 8'hA1;
    localparam logic [7:0] LATIN_HI   = 8'hAC;
    localparam logic [7:0] LATIN2_LO  = 8'hAE;

    // shifted codes for the non-printable bytes
    localparam logic [20:0] EXTRA_FIRST = 21'd256;
    localparam logic [6:0]  EXTRA_COUNT = 7'd68;
    localparam logic [6:0]  EXTRA_CTRL  = 7'd33;   // 0x00-0x20
    localparam logic [6:0]  EXTRA_HIGH  = 7'd67;   // up to 0x7F-0xA0
    localparam logic [7:0]  HIGH_OFFSET = 8'h5E;   // 0x7F - 33
    localparam logic [7:0]  SOFT_HYPHEN = 8'hAD;

    typedef struct packed {
        logic [1:0]  held_cnt;
        logic [2:0]  exp_len;
        logic [20:0] partial;
    } seq_state_t;

    typedef struct packed {
        logic [MAX_RES-1:0][7:0] bytes;
        logic [MAX_RES-1:0]      maps;
        logic [2:0]              count;
    } res_list_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] value;
    } map_t;

    function automatic map_t cp_lookup(input logic [20:0] cp);
        map_t       r;
        logic [20:0] k_full;
        logic [6:0] k;
        r      = '{hit: 1'b0, value: cp[7:0]};
        k_full = cp - EXTRA_FIRST;
        k      = k_full[6:0];
        if (cp[20:8] == '0) begin
            r.hit = ((cp[7:0] >= PRINT_LO) && (cp[7:0] <= PRINT_HI)) ||
                    ((cp[7:0] >= LATIN_LO) && (cp[7:0] <= LATIN_HI)) ||
                    (cp[7:0] >= LATIN2_LO);
        end else if ((cp >= EXTRA_FIRST) && (k_full < {14'd0, EXTRA_COUNT})) begin
            r.hit = 1'b1;
            if (k < EXTRA_CTRL) begin
                r.value = {1'b0, k};
            end else if (k < EXTRA_HIGH) begin
                r.value = {1'b0, k} + HIGH_OFFSET;
            end else begin
                r.value = SOFT_HYPHEN;
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/utf8tok_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8tok_decode: per-byte sequence decode
// Combines one incoming byte with the held sequence state and builds the
// list of output bytes plus the next sequence state.
// ----------------------------------------------------------------------------
module utf8tok_decode (
    input  logic [7:0]                  byte_in,
    input  logic                        text_last,
    input  utf8tok_pkg::seq_state_t     cur,
    input  logic [2:0][7:0]             held_bytes,
    output utf8tok_pkg::seq_state_t     nxt,
    output logic [2:0][7:0]             held_next,
    output utf8tok_pkg::res_list_t      res
);
    import utf8tok_pkg::*;

    logic        is_cont;
    logic [20:0] cp;
    map_t        cp_map;
    map_t        ascii_map;
    logic        complete;
    logic [1:0]  flush_cnt;
    logic        tail_vld;
    logic [7:0]  tail_byte;
    logic        tail_map;
    logic        start_fresh;
    logic [2:0]  lead_len;
    logic [20:0] lead_bits;

    assign is_cont   = (byte_in & CONT_MASK) == CONT_CODE;
    assign cp        = {cur.partial[14:0], byte_in[5:0]};
    assign cp_map    = cp_lookup(cp);
    assign ascii_map = cp_lookup({13'd0, byte_in});
    assign complete  = ({1'b0, cur.held_cnt} + 3'd1) >= cur.exp_len;

    always_comb begin
        if ((byte_in & LEAD2_MASK) == LEAD2_CODE) begin
            lead_len  = 3'd2;
            lead_bits = {16'd0, byte_in[4:0]};
        end else if ((byte_in & LEAD3_MASK) == LEAD3_CODE) begin
            lead_len  = 3'd3;
            lead_bits = {17'd0, byte_in[3:0]};
        end else if ((byte_in & LEAD4_MASK) == LEAD4_CODE) begin
            lead_len  = 3'd4;
            lead_bits = {18'd0, byte_in[2:0]};
        end else begin
            lead_len  = 3'd0;
            lead_bits = '0;
        end
    end

    always_comb begin
        nxt         = cur;
        held_next   = held_bytes;
        flush_cnt   = 2'd0;
        tail_vld    = 1'b0;
        tail_byte   = byte_in;
        tail_map    = 1'b0;
        start_fresh = 1'b0;

        if (cur.held_cnt != 2'd0) begin
            if (is_cont) begin
                if (complete) begin
                    tail_vld = 1'b1;
                    if (cp_map.hit) begin
                        tail_byte = cp_map.value;
                        tail_map  = 1'b1;
                    end else begin
                        flush_cnt = cur.held_cnt;
                    end
                    nxt = '0;
                end else if (text_last) begin
                    flush_cnt = cur.held_cnt;
                    tail_vld  = 1'b1;
                    nxt       = '0;
                end else begin
                    // still short of the announced length: keep gathering
                    held_next[cur.held_cnt] = byte_in;
                    nxt.held_cnt            = cur.held_cnt + 2'd1;
                    nxt.partial             = cp;
                end
            end else begin
                // broken sequence: flush held bytes, then treat byte as new
                flush_cnt   = cur.held_cnt;
                nxt         = '0;
                start_fresh = 1'b1;
            end
        end else begin
            start_fresh = 1'b1;
        end

        if (start_fresh) begin
            if (!byte_in[7]) begin
                tail_vld = 1'b1;
                tail_map = ascii_map.hit;
            end else if ((lead_len != 3'd0) && !text_last) begin
                held_next[0] = byte_in;
                nxt.held_cnt = 2'd1;
                nxt.exp_len  = lead_len;
                nxt.partial  = lead_bits;
            end else begin
                tail_vld = 1'b1;
            end
        end

        if (text_last) begin
            nxt = '0;
        end
    end

    always_comb begin
        for (int i = 0; i < HELD_MAX; i++) begin
            if (2'(i) < flush_cnt) begin
                res.bytes[i] = held_bytes[i];
                res.maps[i]  = 1'b0;
            end else begin
                res.bytes[i] = tail_byte;
                res.maps[i]  = tail_map;
            end
        end
        res.bytes[MAX_RES-1] = tail_byte;
        res.maps[MAX_RES-1]  = tail_map;
        res.count            = {1'b0, flush_cnt} + {2'd0, tail_vld};
    end

endmodule
`default_nettype wire

// ===== rtl/utf8_byte_level_token_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_byte_level_token_decoder: byte-level BPE text to raw bytes
// Gathers UTF-8 sequences from joined token text and maps each code point
// back through the byte-level table; failed or unmapped sequences come out raw.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel: one text byte per transaction, s_text_last on the final byte.
//   m_* channel: zero to four output bytes per input transaction; m_run_last
//   marks the last byte caused by one input, m_text_done the end of the text.
//   An input byte is decoded in the cycle it is accepted and its results sit
//   in the output buffer from the next cycle on.
//   Throughput: one input per cycle while m_ready is high and each input gives
//   at most one byte. An input that gives n > 1 bytes occupies the output
//   buffer until all n are taken; the next input is taken in the cycle the last
//   of them is transferred. Inputs that only extend a sequence give no output.
//   When the receiver stalls, the buffered bytes hold and s_ready stays low
//   while any byte is pending; it rises in the cycle the last one is taken.
//   Reset (aresetn low, synchronous) empties the output buffer and drops any
//   partially gathered sequence.
// ----------------------------------------------------------------------------
module utf8_byte_level_token_decoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_byte_in,
    input  logic       s_text_last,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_byte_out,
    output logic       m_from_map,
    output logic       m_run_last,
    output logic       m_text_done
);
    import utf8tok_pkg::*;

    seq_state_t              seq_reg;
    seq_state_t              seq_next;
    logic [2:0][7:0]         held_reg;
    logic [2:0][7:0]         held_next;
    res_list_t               dec_res;

    logic [MAX_RES-1:0][7:0] buf_byte_reg;
    logic [MAX_RES-1:0]      buf_map_reg;
    logic [2:0]              buf_cnt_reg;
    logic                    buf_last_reg;

    logic                    s_fire;
    logic                    m_fire;

    utf8tok_decode u_decode (
        .byte_in    (s_byte_in),
        .text_last  (s_text_last),
        .cur        (seq_reg),
        .held_bytes (held_reg),
        .nxt        (seq_next),
        .held_next  (held_next),
        .res        (dec_res)
    );

    assign m_valid = buf_cnt_reg != 3'd0;
    assign m_fire  = m_valid && m_ready;
    assign s_ready = (buf_cnt_reg == 3'd0) || ((buf_cnt_reg == 3'd1) && m_ready);
    assign s_fire  = s_valid && s_ready;

    assign m_byte_out  = buf_byte_reg[0];
    assign m_from_map  = buf_map_reg[0];
    assign m_run_last  = buf_cnt_reg == 3'd1;
    assign m_text_done = (buf_cnt_reg == 3'd1) && buf_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg     <= '0;
            buf_cnt_reg <= 3'd0;
        end else begin
            if (s_fire) begin
                seq_reg     <= seq_next;
                buf_cnt_reg <= dec_res.count;
            end else if (m_fire) begin
                buf_cnt_reg <= buf_cnt_reg - 3'd1;
            end
        end
    end

    // payload: held bytes and output buffer carry no reset
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            held_reg     <= held_next;
            buf_byte_reg <= dec_res.bytes;
            buf_map_reg  <= dec_res.maps;
            buf_last_reg <= s_text_last;
        end else if (m_fire) begin
            for (int i = 0; i < MAX_RES - 1; i++) begin
                buf_byte_reg[i] <= buf_byte_reg[i+1];
                buf_map_reg[i]  <= buf_map_reg[i+1];
            end
        end
    end

`ifndef ASSERT_OFF
    a_buf_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        buf_cnt_reg <= 3'd4)
        else $error("output buffer count out of range");

    a_held_below_len: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_reg.held_cnt != 2'd0 |->
            ({1'b0, seq_reg.held_cnt} < seq_reg.exp_len) && (seq_reg.exp_len <= 3'd4))
        else $error("held byte count not below announced length");

    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        seq_reg.held_cnt == 2'd0 |-> (seq_reg.exp_len == 3'd0) && (seq_reg.partial == '0))
        else $error("sequence state left over with nothing held");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_text_last |=> seq_reg.held_cnt == 2'd0)
        else $error("bytes still held after end of text");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |-> (buf_cnt_reg == 3'd0) || m_fire)
        else $error("input accepted over pending output");
`endif

endmodule
`default_nettype wire

// ===== dv/tb_utf8_byte_level_token_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_byte_level_token_decoder: self-checking bench for the token decoder
// Drives text bytes through the s_ channel and checks every m_ output byte
// against a behavioral decoder or the byte a typed row gives. A short list
// of hand-picked bytes comes first, then random UTF-8 text with broken and
// cut-off sequences, under random backpressure and one long output stall.
// ----------------------------------------------------------------------------
module tb_utf8_byte_level_token_decoder;

    localparam int CYCLE_LIMIT   = 200_000;
    localparam int ITEMS_PER_RUN = 110;
    localparam int LONG_HOLD     = 64;
    localparam int SHIFT_FIRST   = 256;  // first code point of the shifted block
    localparam int SHIFT_COUNT   = 68;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       from_map;
        logic       run_last;
        logic       text_done;
    } out_beat_t;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
    } text_byte_t;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
        logic       typed;
        logic [7:0] t_byte;
        logic       t_map;
    } dir_row_t;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       s_valid     = 1'b0;
    logic       s_ready;
    logic [7:0] s_byte_in   = 8'h00;
    logic       s_text_last = 1'b0;
    logic       m_valid;
    logic       m_ready     = 1'b0;
    logic [7:0] m_byte_out;
    logic       m_from_map;
    logic       m_run_last;
    logic       m_text_done;

    // decoder state mirror
    logic [7:0]  held_seq [3] = '{8'h00, 8'h00, 8'h00};
    logic [1:0]  held_cnt = 2'd0;
    logic [2:0]  need_len = 3'd0;
    logic [20:0] acc_cp   = 21'd0;

    out_beat_t  step_out [$];
    out_beat_t  exp_q [$];
    text_byte_t text_q [$];

    int send_idle = 38;
    int recv_idle = 52;
    int phase     = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    int err_cnt   = 0;
    int cycle_cnt = 0;

    // hand-picked opening bytes; typed rows carry their single expected byte
    localparam int N_OPEN = 27;
    dir_row_t opening_rows [N_OPEN] = '{
        '{8'h41, 1'b0, 1'b1, 8'h41, 1'b1},  // printable ASCII maps to itself
        '{8'h00, 1'b0, 1'b1, 8'h00, 1'b0},  // low ASCII is raw
        '{8'h7F, 1'b0, 1'b1, 8'h7F, 1'b0},
        '{8'h7E, 1'b0, 1'b1, 8'h7E, 1'b1},
        '{8'h80, 1'b0, 1'b1, 8'h80, 1'b0},  // stray continuation
        '{8'hFF, 1'b0, 1'b1, 8'hFF, 1'b0},  // invalid lead
        '{8'hC4, 1'b0, 1'b0, 8'h00, 1'b0},  // U+0100 -> 0x00
        '{8'h80, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'hC5, 1'b0, 1'b0, 8'h00, 1'b0},  // U+0143 -> 0xAD, top of shifted block
        '{8'h83, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'hC2, 1'b0, 1'b0, 8'h00, 1'b0},  // U+00AD is unmapped
        '{8'hAD, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'hE0, 1'b0, 1'b0, 8'h00, 1'b0},  // overlong zero, raw
        '{8'h80, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h80, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'hF0, 1'b0, 1'b0, 8'h00, 1'b0},  // four raw bytes from one input
        '{8'h80, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h80, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'h80, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'hE2, 1'b0, 1'b0, 8'h00, 1'b0},  // broken by a new lead
        '{8'h82, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'hC3, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'hA9, 1'b0, 1'b0, 8'h00, 1'b0},
        '{8'hE2, 1'b0, 1'b0, 8'h00, 1'b0},  // cut off by end of text
        '{8'h82, 1'b1, 1'b0, 8'h00, 1'b0},
        '{8'hC3, 1'b1, 1'b1, 8'hC3, 1'b0},  // lead on the last byte
        '{8'h41, 1'b1, 1'b1, 8'h41, 1'b1}
    };

    utf8_byte_level_token_decoder i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_byte_in   (s_byte_in),
        .s_text_last (s_text_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_byte_out  (m_byte_out),
        .m_from_map  (m_from_map),
        .m_run_last  (m_run_last),
        .m_text_done (m_text_done)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------- behavioral decoder ----------------

    function automatic bit byte_table(input logic [20:0] cp, output logic [7:0] b);
        int k;
        b = cp[7:0];
        if (cp < 21'd256) begin
            return (cp >= 21'h21 && cp <= 21'h7E) || (cp >= 21'hA1 && cp <= 21'hAC) ||
                   (cp >= 21'hAE);
        end
        if (cp >= SHIFT_FIRST && cp < SHIFT_FIRST + SHIFT_COUNT) begin
            k = int'(cp) - SHIFT_FIRST;
            if (k < 33) begin
                b = 8'(k);
            end else if (k < 67) begin
                b = 8'(8'h7F + (k - 33));
            end else begin
                b = 8'hAD;
            end
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void emit_byte(input logic [7:0] b, input logic mapped);
        step_out.insert(step_out.size(), out_beat_t'{b, mapped, 1'b0, 1'b0});
    endfunction

    function automatic void drop_held();
        held_cnt = 2'd0;
        need_len = 3'd0;
        acc_cp   = 21'd0;
    endfunction

    function automatic void flush_held();
        for (int i = 0; i < held_cnt; i++) emit_byte(held_seq[i], 1'b0);
        drop_held();
    endfunction

    function automatic void start_fresh(input logic [7:0] c, input logic last);
        logic [7:0] m;
        if (!c[7]) begin
            if (byte_table({13'd0, c}, m)) emit_byte(m, 1'b1);
            else emit_byte(c, 1'b0);
        end else if (last) begin
            emit_byte(c, 1'b0);
        end else if (c[7:5] == 3'b110) begin
            held_seq[0] = c; held_cnt = 2'd1; need_len = 3'd2; acc_cp = {16'd0, c[4:0]};
        end else if (c[7:4] == 4'b1110) begin
            held_seq[0] = c; held_cnt = 2'd1; need_len = 3'd3; acc_cp = {17'd0, c[3:0]};
        end else if (c[7:3] == 5'b11110) begin
            held_seq[0] = c; held_cnt = 2'd1; need_len = 3'd4; acc_cp = {18'd0, c[2:0]};
        end else begin
            emit_byte(c, 1'b0);
        end
    endfunction

    function automatic void predict_byte(input logic [7:0] c, input logic last);
        logic [20:0] cp;
        logic [7:0]  m;
        step_out.delete();
        if (held_cnt != 0) begin
            if (c[7:6] == 2'b10) begin
                cp = {acc_cp[14:0], c[5:0]};
                if (int'(held_cnt) + 1 >= int'(need_len)) begin
                    if (byte_table(cp, m)) begin
                        emit_byte(m, 1'b1);
                    end else begin
                        for (int i = 0; i < held_cnt; i++) emit_byte(held_seq[i], 1'b0);
                        emit_byte(c, 1'b0);
                    end
                    drop_held();
                end else if (last) begin
                    flush_held();
                    emit_byte(c, 1'b0);
                end else begin
                    held_seq[held_cnt] = c;
                    held_cnt = held_cnt + 2'd1;
                    acc_cp = cp;
                end
            end else begin
                flush_held();
                start_fresh(c, last);
            end
        end else begin
            start_fresh(c, last);
        end
        if (last) drop_held();
        if (step_out.size() > 0) begin
            step_out[step_out.size() - 1].run_last  = 1'b1;
            step_out[step_out.size() - 1].text_done = last;
        end
    endfunction

    // ---------------- stimulus ----------------

    task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                             input logic [7:0] t_byte, input logic t_map);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_byte_in   <= b;
        s_text_last <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_byte(b, last);
        if (typed) exp_q.insert(exp_q.size(), out_beat_t'{t_byte, t_map, 1'b1, last});
        else foreach (step_out[i]) exp_q.insert(exp_q.size(), step_out[i]);
    endtask

    function automatic void add_text(input logic [7:0] b);
        text_q.insert(text_q.size(), text_byte_t'{b, logic'($urandom_range(99) < 3)});
    endfunction

    function automatic logic [7:0] lead_of(input int len);
        logic [7:0] r;
        r = 8'($urandom_range(255));
        case (len)
            2: r[7:5] = 3'b110;
            3: r[7:4] = 4'b1110;
            default: r[7:3] = 5'b11110;
        endcase
        return r;
    endfunction

    function automatic void add_piece();
        int         kind;
        int         len;
        int         cp;
        logic [7:0] b;
        kind = $urandom_range(99);
        if (kind < 45) begin
            // code point from the byte table
            case ($urandom_range(3))
                0, 1: cp = $urandom_range(SHIFT_FIRST + SHIFT_COUNT - 1, SHIFT_FIRST);
                2: cp = $urandom_range(8'hFF, 8'hA1);
                default: cp = $urandom_range(8'h7F, 0);
            endcase
            if (cp < 'h80) begin
                add_text(8'(cp));
            end else begin
                add_text({3'b110, 5'(cp >> 6)});
                add_text({2'b10, 6'(cp)});
            end
        end else if (kind < 65) begin
            // well-formed shape, random content
            len = $urandom_range(4, 1);
            if (len == 1) add_text({1'b0, 7'($urandom_range(127))});
            else add_text(lead_of(len));
            for (int i = 1; i < len; i++) add_text({2'b10, 6'($urandom_range(63))});
        end else if (kind < 80) begin
            // sequence broken by a non-continuation byte
            len = $urandom_range(4, 2);
            add_text(lead_of(len));
            for (int i = $urandom_range(len - 2); i > 0; i--)
                add_text({2'b10, 6'($urandom_range(63))});
            b = 8'($urandom_range(255));
            if (b[7:6] == 2'b10) b[6] = 1'b1;
            add_text(b);
        end else begin
            add_text(8'($urandom_range(255)));
        end
        if ($urandom_range(99) < 10) begin
            text_q[text_q.size() - 1].last = 1'b1;
        end
    endfunction

    task automatic run_random(input int n);
        text_byte_t t;
        while (text_q.size() < n) add_piece();
        while (text_q.size() > 0) begin
            t = text_q.pop_front();
            send_byte(t.b, t.last, 1'b0, 8'h00, 1'b0);
        end
    endtask

    // ---------------- receiver, checker, watchdog ----------------

    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (phase == 2 && !hold_done) begin
            // long stall so the output buffer fills and s_ready drops
            m_ready   <= 1'b0;
            hold_left <= LONG_HOLD;
            hold_done <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %02h, got %02h",
                     $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin : check_out
        out_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (exp_q.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected transaction, expected none, got byte %02h",
                         $time, m_byte_out);
            end else begin
                want = exp_q.pop_front();
                check_field("byte_out", want.byte_out, m_byte_out);
                check_field("from_map", {7'd0, want.from_map}, {7'd0, m_from_map});
                check_field("run_last", {7'd0, want.run_last}, {7'd0, m_run_last});
                check_field("text_done", {7'd0, want.text_done}, {7'd0, m_text_done});
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("utf8_byte_level_token_decoder verification failed");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (opening_rows[i])
            send_byte(opening_rows[i].b, opening_rows[i].last, opening_rows[i].typed,
                      opening_rows[i].t_byte, opening_rows[i].t_map);
        run_random(ITEMS_PER_RUN);

        send_idle = 52;
        recv_idle = 38;
        phase     = 1;
        run_random(ITEMS_PER_RUN);

        send_idle = 0;
        recv_idle = 0;
        phase     = 2;
        run_random(ITEMS_PER_RUN);

        s_valid <= 1'b0;
        while (exp_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (err_cnt == 0) begin
            $display("utf8_byte_level_token_decoder verification clean");
        end else begin
            $display("utf8_byte_level_token_decoder verification failed");
        end
        $finish;
    end

endmodule
